// ===== hdl/ctt_pkg.sv =====
// ----------------------------------------------------------------------------
// ctt_pkg - shared types and constants of the config text tokenizer
// Character codes, lexer modes, result word layout and small helpers used by
// the lexer stage, the result queue and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ctt_pkg;

   // Result bundle sizing: one text byte gives at most this many results
   localparam int MAX_RESULTS = 4;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int IDX_W       = $clog2(MAX_RESULTS);

   // Token buffer size register
   localparam int                CAP_W       = 13;
   localparam int                LEN_W       = 12;
   localparam logic [CAP_W-1:0]  CAP_RESET   = 13'd256;
   localparam logic [CAP_W-1:0]  CAP_MIN     = 13'd2;
   localparam logic [CAP_W-1:0]  CAP_MAX     = 13'd4096;

   // Result kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Character codes
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_DASH   = 8'h2D;

   // Lexer modes, one-hot
   typedef enum logic [5:0] {
      MODE_IDLE       = 6'b000001,
      MODE_WORD       = 6'b000010,
      MODE_QUOTED     = 6'b000100,
      MODE_LINE       = 6'b001000,
      MODE_BLOCK      = 6'b010000,
      MODE_BLOCK_STAR = 6'b100000
   } ctt_mode_type;

   // One result word
   typedef struct packed {
      logic       kind;
      logic [7:0] tok;
      logic       quoted;
   } ctt_result_type;

   // Results of one text byte, handed from lexer to result queue
   typedef struct packed {
      logic                                   load;
      logic [CNT_W-1:0]                       count;
      ctt_result_type [MAX_RESULTS-1:0]       res;
   } ctt_bundle_type;

   // Characters that form a token on their own
   function automatic logic is_single(input logic [7:0] b);
      return b inside {CHAR_LBRACE, CHAR_RBRACE, CHAR_LPAREN, CHAR_RPAREN,
                       CHAR_SQUOTE, CHAR_COLON, CHAR_COMMA, CHAR_DASH};
   endfunction

   // Largest character count of a token, with the register clamped to range
   function automatic logic [LEN_W-1:0] char_limit(input logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0] c;
      logic [CAP_W-1:0] m1;
      c = cap;
      if (c < CAP_MIN) c = CAP_MIN;
      if (c > CAP_MAX) c = CAP_MAX;
      m1 = c - 13'd1;
      return m1[LEN_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ctt_req_if.sv =====
// ----------------------------------------------------------------------------
// ctt_req_if - text byte channel
// Valid/ready channel carrying one text byte and the end-of-text flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] input_byte;
   logic       end_of_text;

   modport source (output valid, output input_byte, output end_of_text, input ready);
   modport sink   (input valid, input input_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== hdl/ctt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ctt_rsp_if - token result channel
// Valid/ready channel carrying one token character or token end marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctt_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] token_byte;
   logic       was_quoted;
   logic       run_last;

   modport source (output valid, output result_kind, output token_byte,
                   output was_quoted, output run_last, input ready);
   modport sink   (input valid, input result_kind, input token_byte,
                   input was_quoted, input run_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/ctt_csr_if.sv =====
// ----------------------------------------------------------------------------
// ctt_csr_if - configuration write channel
// Valid/ready channel carrying the token buffer size register value.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctt_csr_if;
   logic        valid;
   logic        ready;
   logic [12:0] token_capacity;

   modport source (output valid, output token_capacity, input ready);
   modport sink   (input valid, input token_capacity, output ready);
endinterface

`default_nettype wire

// ===== hdl/ctt_lexer.sv =====
// ----------------------------------------------------------------------------
// ctt_lexer - input register and lexer state update
// Holds the accepted text byte, works out the results it causes together with
// the next lexer state, and hands the results to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_lexer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ctt_req_if.sink                             req_ch,
   input  wire logic [ctt_pkg::LEN_W-1:0]      char_lim,
   input  wire logic                           queue_free,
   output ctt_pkg::ctt_bundle_type             bundle
);

   // Input register
   logic                         in_valid_ff;
   logic [7:0]                   in_byte_ff;
   logic                         in_eot_ff;
   logic                         in_move;

   // Lexer state
   ctt_pkg::ctt_mode_type        mode_ff, mode_in;
   logic [ctt_pkg::LEN_W-1:0]    len_ff, len_in;
   logic                         slash_ff, slash_in;

   // Results of the held byte
   logic [ctt_pkg::CNT_W-1:0]                     cnt_v;
   ctt_pkg::ctt_result_type [ctt_pkg::MAX_RESULTS-1:0] res_v;
   logic                                          eot_v;
   logic                                          do_idle;

   // Work out results and next state of the held byte
   always_comb begin
      mode_in  = mode_ff;
      len_in   = len_ff;
      slash_in = slash_ff;
      cnt_v    = '0;
      res_v    = '0;
      do_idle  = 1'b0;
      eot_v    = in_eot_ff || (in_byte_ff == ctt_pkg::CHAR_NUL);

      if (eot_v) begin
         // flush a held slash and any open token, then drop to idle
         if (slash_in) begin
            res_v[cnt_v[ctt_pkg::IDX_W-1:0]] = '{ctt_pkg::KIND_CHAR, ctt_pkg::CHAR_SLASH, 1'b0};
            cnt_v = cnt_v + 1'b1;
         end
         if (slash_in || mode_in == ctt_pkg::MODE_WORD) begin
            res_v[cnt_v[ctt_pkg::IDX_W-1:0]] = '{ctt_pkg::KIND_END, 8'h00, 1'b0};
            cnt_v = cnt_v + 1'b1;
         end else if (mode_in == ctt_pkg::MODE_QUOTED) begin
            res_v[cnt_v[ctt_pkg::IDX_W-1:0]] = '{ctt_pkg::KIND_END, 8'h00, 1'b1};
            cnt_v = cnt_v + 1'b1;
         end
         mode_in  = ctt_pkg::MODE_IDLE;
         len_in   = '0;
         slash_in = 1'b0;
      end else if (slash_in && (in_byte_ff == ctt_pkg::CHAR_SLASH ||
                                in_byte_ff == ctt_pkg::CHAR_STAR)) begin
         // held slash opens a comment: close any word first
         if (mode_in == ctt_pkg::MODE_WORD) begin
            res_v[cnt_v[ctt_pkg::IDX_W-1:0]] = '{ctt_pkg::KIND_END, 8'h00, 1'b0};
            cnt_v = cnt_v + 1'b1;
         end
         mode_in  = (in_byte_ff == ctt_pkg::CHAR_SLASH) ? ctt_pkg::MODE_LINE
                                                        : ctt_pkg::MODE_BLOCK;
         len_in   = '0;
         slash_in = 1'b0;
      end else begin
         // release a held slash as a word character
         if (slash_in) begin
            slash_in = 1'b0;
            if (mode_in != ctt_pkg::MODE_WORD) len_in = '0;
            mode_in = ctt_pkg::MODE_WORD;
            res_v[cnt_v[ctt_pkg::IDX_W-1:0]] = '{ctt_pkg::KIND_CHAR, ctt_pkg::CHAR_SLASH, 1'b0};
            cnt_v  = cnt_v + 1'b1;
            len_in = len_in + 1'b1;
         end

         case (mode_in)
            ctt_pkg::MODE_WORD: begin
               if (len_in >= char_lim || in_byte_ff <= ctt_pkg::CHAR_SPACE ||
                   ctt_pkg::is_single(in_byte_ff)) begin
                  res_v[cnt_v[ctt_pkg::IDX_W-1:0]] = '{ctt_pkg::KIND_END, 8'h00, 1'b0};
                  cnt_v   = cnt_v + 1'b1;
                  do_idle = 1'b1;
               end else if (in_byte_ff == ctt_pkg::CHAR_SLASH) begin
                  slash_in = 1'b1;
               end else begin
                  res_v[cnt_v[ctt_pkg::IDX_W-1:0]] = '{ctt_pkg::KIND_CHAR, in_byte_ff, 1'b0};
                  cnt_v  = cnt_v + 1'b1;
                  len_in = len_in + 1'b1;
               end
            end
            ctt_pkg::MODE_QUOTED: begin
               if (in_byte_ff == ctt_pkg::CHAR_DQUOTE) begin
                  res_v[cnt_v[ctt_pkg::IDX_W-1:0]] = '{ctt_pkg::KIND_END, 8'h00, 1'b1};
                  cnt_v   = cnt_v + 1'b1;
                  mode_in = ctt_pkg::MODE_IDLE;
                  len_in  = '0;
               end else if (len_in >= char_lim) begin
                  res_v[cnt_v[ctt_pkg::IDX_W-1:0]] = '{ctt_pkg::KIND_END, 8'h00, 1'b1};
                  cnt_v   = cnt_v + 1'b1;
                  do_idle = 1'b1;
               end else begin
                  res_v[cnt_v[ctt_pkg::IDX_W-1:0]] = '{ctt_pkg::KIND_CHAR, in_byte_ff, 1'b0};
                  cnt_v  = cnt_v + 1'b1;
                  len_in = len_in + 1'b1;
               end
            end
            ctt_pkg::MODE_LINE: begin
               if (in_byte_ff == ctt_pkg::CHAR_NL) mode_in = ctt_pkg::MODE_IDLE;
            end
            ctt_pkg::MODE_BLOCK: begin
               if (in_byte_ff == ctt_pkg::CHAR_STAR) mode_in = ctt_pkg::MODE_BLOCK_STAR;
            end
            ctt_pkg::MODE_BLOCK_STAR: begin
               if (in_byte_ff == ctt_pkg::CHAR_SLASH) mode_in = ctt_pkg::MODE_IDLE;
               else if (in_byte_ff != ctt_pkg::CHAR_STAR) mode_in = ctt_pkg::MODE_BLOCK;
            end
            ctt_pkg::MODE_IDLE: begin
               do_idle = 1'b1;
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase

         // handle the byte as if between tokens
         if (do_idle) begin
            mode_in = ctt_pkg::MODE_IDLE;
            len_in  = '0;
            if (in_byte_ff <= ctt_pkg::CHAR_SPACE) begin
               mode_in = ctt_pkg::MODE_IDLE;
            end else if (in_byte_ff == ctt_pkg::CHAR_SLASH) begin
               slash_in = 1'b1;
            end else if (in_byte_ff == ctt_pkg::CHAR_DQUOTE) begin
               mode_in = ctt_pkg::MODE_QUOTED;
            end else if (ctt_pkg::is_single(in_byte_ff)) begin
               res_v[cnt_v[ctt_pkg::IDX_W-1:0]] = '{ctt_pkg::KIND_CHAR, in_byte_ff, 1'b0};
               cnt_v = cnt_v + 1'b1;
               res_v[cnt_v[ctt_pkg::IDX_W-1:0]] = '{ctt_pkg::KIND_END, 8'h00, 1'b0};
               cnt_v = cnt_v + 1'b1;
            end else begin
               mode_in = ctt_pkg::MODE_WORD;
               len_in  = {{(ctt_pkg::LEN_W-1){1'b0}}, 1'b1};
               res_v[cnt_v[ctt_pkg::IDX_W-1:0]] = '{ctt_pkg::KIND_CHAR, in_byte_ff, 1'b0};
               cnt_v = cnt_v + 1'b1;
            end
         end
      end
   end

   // Advance the held byte once the queue can take its results
   assign in_move       = in_valid_ff && (queue_free || cnt_v == '0);
   assign req_ch.ready  = !in_valid_ff || in_move;

   assign bundle.load  = in_move && (cnt_v != '0);
   assign bundle.count = cnt_v;
   assign bundle.res   = res_v;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.input_byte;
         in_eot_ff  <= req_ch.end_of_text;
      end
   end

   // Lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ctt_pkg::MODE_IDLE;
         len_ff   <= '0;
         slash_ff <= 1'b0;
      end else if (in_move) begin
         mode_ff  <= mode_in;
         len_ff   <= len_in;
         slash_ff <= slash_in;
      end
   end

   // End of text leaves the lexer in its reset state
   a_eot_resets: assert property (@(posedge clock) disable iff (reset)
      (in_move && eot_v) |=> (mode_ff == ctt_pkg::MODE_IDLE && !slash_ff && len_ff == '0))
      else $error("lexer state not cleared after end of text");

   // A slash is held only between tokens or inside a word
   a_slash_mode: assert property (@(posedge clock) disable iff (reset)
      slash_ff |-> (mode_ff == ctt_pkg::MODE_IDLE || mode_ff == ctt_pkg::MODE_WORD))
      else $error("slash held in a comment or quoted token");

   // Comments carry no token length
   a_comment_len: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == ctt_pkg::MODE_LINE || mode_ff == ctt_pkg::MODE_BLOCK ||
       mode_ff == ctt_pkg::MODE_BLOCK_STAR) |-> (len_ff == '0))
      else $error("token length left over inside a comment");

endmodule

`default_nettype wire

// ===== hdl/ctt_result_queue.sv =====
// ----------------------------------------------------------------------------
// ctt_result_queue - result register and serialiser
// Holds the results of one text byte and delivers them one word at a time,
// marking the last word of each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_result_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ctt_pkg::ctt_bundle_type bundle,
   output logic                         queue_free,
   ctt_rsp_if.source                    rsp_ch
);

   logic                                               valid_ff;
   logic [ctt_pkg::CNT_W-1:0]                          cnt_ff;
   logic [ctt_pkg::IDX_W-1:0]                          idx_ff;
   ctt_pkg::ctt_result_type [ctt_pkg::MAX_RESULTS-1:0] res_ff;
   logic                                               last;
   logic                                               pop;

   // Current word and the end of the byte's run
   assign last = ({1'b0, idx_ff} == cnt_ff - 1'b1);
   assign pop  = valid_ff && rsp_ch.ready;

   assign queue_free = !valid_ff || (pop && last);

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.result_kind = res_ff[idx_ff].kind;
   assign rsp_ch.token_byte  = res_ff[idx_ff].tok;
   assign rsp_ch.was_quoted  = res_ff[idx_ff].quoted;
   assign rsp_ch.run_last    = last;

   // Load a new run or advance through the held one
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (bundle.load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (pop) begin
         if (last) begin
            valid_ff <= 1'b0;
         end
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (bundle.load) begin
         cnt_ff <= bundle.count;
         res_ff <= bundle.res;
      end
   end

   // The word index stays inside the held run
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ({1'b0, idx_ff} < cnt_ff))
      else $error("result index beyond held run");

   // A new run never overwrites words still to deliver
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      bundle.load |-> queue_free)
      else $error("result run loaded over a busy queue");

   // Empty runs are never loaded
   a_no_empty: assert property (@(posedge clock) disable iff (reset)
      bundle.load |-> (bundle.count != '0))
      else $error("empty result run loaded");

endmodule

`default_nettype wire

// ===== hdl/config_text_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// config_text_tokenizer_core - streaming text tokenizer
// Splits configuration text into tokens, skipping comments and unquoting
// quoted strings.
// ----------------------------------------------------------------------------
// Text enters one byte per word on req_ch; tokens leave on rsp_ch as runs of
// character words, each closed by an end marker word, with run_last set on
// the final word caused by each text byte. A byte is taken every cycle while
// each byte yields at most one result word and rsp_ch is ready; a byte
// yielding n words (up to four) holds the single result port until its last
// word is taken, stalling the input register. Bytes pass the input register,
// then the result register. The token buffer size is written on csr_ch,
// which is always ready; write it only while no text is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module config_text_tokenizer_core (
   input  wire logic   clock,
   input  wire logic   reset,
   ctt_req_if.sink     req_ch,
   ctt_rsp_if.source   rsp_ch,
   ctt_csr_if.sink     csr_ch
);

   logic [ctt_pkg::CAP_W-1:0]  cap_ff;
   logic [ctt_pkg::LEN_W-1:0]  char_lim;
   logic                       queue_free;
   ctt_pkg::ctt_bundle_type    bundle;

   // Token buffer size register
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= ctt_pkg::CAP_RESET;
      end else if (csr_ch.valid) begin
         cap_ff <= csr_ch.token_capacity;
      end
   end

   // Clamp to the supported range and convert to a character limit
   assign char_lim = ctt_pkg::char_limit(cap_ff);

   ctt_lexer u_lexer (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .char_lim   (char_lim),
      .queue_free (queue_free),
      .bundle     (bundle)
   );

   ctt_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .bundle     (bundle),
      .queue_free (queue_free),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire
